FILE: design/sparse_3d_cell_hash_store_unit_macros.svh
// Assertion macros used by the cell store top level.
`ifndef SPARSE_3D_CELL_HASH_STORE_UNIT_MACROS_SVH
`define SPARSE_3D_CELL_HASH_STORE_UNIT_MACROS_SVH
`ifndef SYNTH
`define S3C_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define S3C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define S3C_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define S3C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/s3c_pkg.sv
// Package with shared types and constants of the sparse 3D cell store.
`default_nettype none
package s3c_pkg;
    localparam logic [31:0] HASH_SEED   = 32'hc0d1f1ed;
    localparam logic [31:0] SPACE_VALUE = 32'd32;
    localparam logic        REQ_WRITE   = 1'b0;
    localparam logic        REQ_READ    = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } s3c_hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hash;
    } s3c_hash_rsp_t;
endpackage
`default_nettype wire

FILE: design/s3c_hash.sv
// Iterative coordinate hash built around one shared 32-bit multiplier.
`default_nettype none
module s3c_hash (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire s3c_pkg::s3c_hash_req_t req,
    output s3c_pkg::s3c_hash_rsp_t     rsp
);
    import s3c_pkg::*;

    logic [31:0] h_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] x_reg, y_reg, z_reg;
    logic [31:0] op;
    logic [31:0] prod;
    logic [31:0] mixed;

    // The multiplier operand for each of the three rounds.
    always_comb
    begin
        case (step_reg)
            2'd0:    op = x_reg | 32'd1;
            2'd1:    op = y_reg | 32'd1;
            default: op = z_reg | 32'd3;
        endcase
    end

    assign prod = h_reg * op;

    always_comb
    begin
        case (step_reg)
            2'd0:    mixed = {prod ^ x_reg} << 3 | (prod ^ x_reg) >> 29;
            2'd1:    mixed = (prod ^ ~y_reg) << 5 | (prod ^ ~y_reg) >> 27;
            default: mixed = prod ^ z_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            z_reg <= req.z;
            h_reg <= HASH_SEED;
        end
        else if (busy_reg)
        begin
            h_reg <= mixed;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hash = h_reg;
endmodule
`default_nettype wire

FILE: design/sparse_3d_cell_hash_store_unit.sv
// Top level of the sparse 3D cell store: hash, bucket scan and update.
// Steps: hash, fill read, a read and compare per entry (at least one compare slot),
// plus the write state for a write, or a last-entry read, compare and move for a delete hit.
// Flow: one request at a time; the next beat is taken after the result leaves.
// Reset: asynchronous active low; fill counts read as zero via per-bucket valid bits.
`default_nettype none
`include "sparse_3d_cell_hash_store_unit_macros.svh"
module sparse_3d_cell_hash_store_unit #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata from bit 0: coord_x[31:0], coord_y, coord_z, write_value (128 bits)
    input  wire logic [127:0] s_tdata,
    // tuser: req_type
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata from bit 0: read_value[31:0], found, dropped, zero pad (40 bits)
    output logic [39:0]       m_tdata
);
    import s3c_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int FW = $clog2(BUCKET_WAYS + 1);
    localparam int AW = BW + WW;
    localparam int DEPTH = NUM_BUCKETS * (1 << WW);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_HASH  = 8'b00000010,
        ST_FILL  = 8'b00000100,
        ST_RD    = 8'b00001000,
        ST_CMP   = 8'b00010000,
        ST_MOVE  = 8'b00100000,
        ST_WRITE = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg;
    logic   is_read_reg;
    logic [31:0] x_reg, y_reg, z_reg, w_reg;
    logic [BW-1:0] bucket_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] idx_reg;
    logic [WW-1:0] hit_reg;
    logic found_reg, dropped_reg;
    logic [31:0] rval_reg;

    logic [FW-1:0] fill_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] fill_valid_reg;

    logic [127:0] ent_mem [DEPTH];
    logic [127:0] ent_q_reg;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [127:0]  wr_data;
    logic          fill_we;
    logic [FW-1:0] fill_wdata;

    s3c_hash_req_t hreq;
    s3c_hash_rsp_t hrsp;

    assign hreq.start = (state_reg == ST_IDLE) && s_tvalid;
    assign hreq.x = s_tdata[31:0];
    assign hreq.y = s_tdata[63:32];
    assign hreq.z = s_tdata[95:64];

    s3c_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, dropped_reg, found_reg, rval_reg};

    always_comb
    begin
        rd_addr = {bucket_reg, idx_reg[WW-1:0]};
        if (state_reg == ST_MOVE || idx_reg >= fill_reg)
            rd_addr = {bucket_reg, WW'(fill_reg - FW'(1))};
    end

    // Entry memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            ent_mem[wr_addr] <= wr_data;
        ent_q_reg <= ent_mem[rd_addr];
        if (fill_we)
            fill_mem[bucket_reg] <= fill_wdata;
    end

    logic match;
    assign match = ent_q_reg[31:0] == x_reg && ent_q_reg[63:32] == y_reg
                   && ent_q_reg[95:64] == z_reg;

    always_comb
    begin
        we = 1'b0;
        wr_addr = {bucket_reg, hit_reg};
        wr_data = {w_reg, z_reg, y_reg, x_reg};
        fill_we = 1'b0;
        fill_wdata = fill_reg;
        if (state_reg == ST_MOVE)
        begin
            we = (WW'(fill_reg - FW'(1)) != hit_reg);
            wr_data = ent_q_reg;
            fill_we = 1'b1;
            fill_wdata = fill_reg - FW'(1);
        end
        else if (state_reg == ST_WRITE)
        begin
            if (found_reg)
            begin
                we = 1'b1;
                wr_data = {w_reg, ent_q_reg[95:0]};
                wr_data[95:0] = {z_reg, y_reg, x_reg};
            end
            else if (!dropped_reg)
            begin
                we = 1'b1;
                wr_addr = {bucket_reg, fill_reg[WW-1:0]};
                fill_we = 1'b1;
                fill_wdata = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_valid_reg <= '0;
        end
        else
        begin
            if (fill_we)
                fill_valid_reg[bucket_reg] <= 1'b1;
            case (state_reg)
                ST_IDLE:  if (s_tvalid) state_reg <= ST_HASH;
                ST_HASH:  if (hrsp.done) state_reg <= ST_FILL;
                ST_FILL:  state_reg <= ST_RD;
                ST_RD:    state_reg <= ST_CMP;
                ST_CMP:
                begin
                    if (idx_reg < fill_reg && match)
                    begin
                        if (is_read_reg) state_reg <= ST_OUT;
                        else if (w_reg == SPACE_VALUE) state_reg <= ST_RD;
                        else state_reg <= ST_WRITE;
                    end
                    else if (idx_reg + FW'(1) < fill_reg)
                        state_reg <= ST_RD;
                    else if (is_read_reg || w_reg == SPACE_VALUE)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_WRITE;
                    if (idx_reg >= fill_reg && found_reg)
                        state_reg <= ST_MOVE;
                    if (fill_reg == '0 && !found_reg)
                        state_reg <= (is_read_reg || w_reg == SPACE_VALUE) ? ST_OUT
                                                                          : ST_WRITE;
                end
                ST_MOVE:  state_reg <= ST_OUT;
                ST_WRITE: state_reg <= ST_OUT;
                ST_OUT:   if (m_tready) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                is_read_reg <= s_tuser;
                x_reg <= s_tdata[31:0];
                y_reg <= s_tdata[63:32];
                z_reg <= s_tdata[95:64];
                w_reg <= s_tdata[127:96];
                found_reg <= 1'b0;
                dropped_reg <= 1'b0;
                rval_reg <= SPACE_VALUE;
                idx_reg <= '0;
            end
            ST_HASH:  bucket_reg <= BW'(hrsp.hash % NUM_BUCKETS);
            ST_FILL:
            begin
                fill_reg <= fill_valid_reg[bucket_reg] ? fill_mem[bucket_reg] : '0;
            end
            ST_CMP:
            begin
                if (idx_reg < fill_reg && match && !found_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg <= idx_reg[WW-1:0];
                    rval_reg <= ent_q_reg[127:96];
                    // Park the index at fill so the next read fetches the last entry.
                    idx_reg <= fill_reg;
                end
                else
                    idx_reg <= idx_reg + FW'(1);
                if (!(idx_reg < fill_reg && match) && idx_reg + FW'(1) >= fill_reg
                    && !found_reg && !is_read_reg && w_reg != SPACE_VALUE
                    && fill_reg >= FW'(BUCKET_WAYS))
                    dropped_reg <= 1'b1;
                if (fill_reg == '0 && !is_read_reg && w_reg != SPACE_VALUE
                    && FW'(BUCKET_WAYS) == '0)
                    dropped_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    `S3C_ASSERT_IMPL(a_out_no_ready, clk, rst_n, !(m_tvalid && s_tready), "in/out overlap")
    `S3C_ASSERT_IMPL(a_fill_bound, clk, rst_n, fill_reg <= FW'(BUCKET_WAYS) || state_reg == ST_IDLE || state_reg == ST_HASH || state_reg == ST_FILL, "fill over ways")
    `S3C_ASSERT_IMPL(a_drop_found, clk, rst_n, !(m_tvalid && found_reg && dropped_reg), "drop with hit")
    `S3C_ASSERT_NEXT(a_accept, clk, rst_n, s_tvalid && s_tready, state_reg == ST_HASH, "no hash start")
endmodule
`default_nettype wire

FILE: tb/sv/cell_store_checker.sv
// Checker that predicts and compares the cell store's result beats.
`timescale 1ns / 1ps
`default_nettype none
module cell_store_checker #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    output int                fail_count,
    output int                pending_count
);
    import s3c_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
        logic        dropped;
    } cell_result_t;

    int unsigned  fill_of [NUM_BUCKETS];
    logic [31:0]  kx [NUM_BUCKETS * BUCKET_WAYS];
    logic [31:0]  ky [NUM_BUCKETS * BUCKET_WAYS];
    logic [31:0]  kz [NUM_BUCKETS * BUCKET_WAYS];
    logic [31:0]  cell_val [NUM_BUCKETS * BUCKET_WAYS];
    cell_result_t expected_results [$];

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic int unsigned bucket_index(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
        logic [31:0] h;
        h = HASH_SEED;
        h = h * (x | 32'd1);
        h = rotl(h ^ x, 3);
        h = h * (y | 32'd1);
        h = rotl(h ^ ~y, 5);
        h = h * (z | 32'd3);
        h = h ^ z;
        return h % NUM_BUCKETS;
    endfunction

    // Applies one request to the shadow table and returns its result.
    function automatic cell_result_t apply_request(logic is_read, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z,
                                                   logic [31:0] wval);
        cell_result_t r;
        int unsigned b, base, fill, hit, last;
        b = bucket_index(x, y, z);
        base = b * BUCKET_WAYS;
        fill = fill_of[b];
        hit = 0;
        r = '{value: SPACE_VALUE, found: 1'b0, dropped: 1'b0};
        for (int i = 0; i < fill; i++) begin
            if (!r.found && kx[base+i] == x && ky[base+i] == y && kz[base+i] == z)
            begin
                r.found = 1'b1;
                hit = base + i;
                r.value = cell_val[base+i];
            end
        end
        if (is_read == REQ_WRITE) begin
            if (wval == SPACE_VALUE) begin
                if (r.found) begin
                    // Delete: the last entry of the bucket fills the hole.
                    last = base + fill - 1;
                    kx[hit] = kx[last];
                    ky[hit] = ky[last];
                    kz[hit] = kz[last];
                    cell_val[hit] = cell_val[last];
                    fill_of[b] = fill - 1;
                end
            end else if (r.found) begin
                cell_val[hit] = wval;
            end else if (fill >= BUCKET_WAYS) begin
                r.dropped = 1'b1;
            end else begin
                kx[base+fill] = x;
                ky[base+fill] = y;
                kz[base+fill] = z;
                cell_val[base+fill] = wval;
                fill_of[b] = fill + 1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        foreach (fill_of[i]) fill_of[i] = 0;
    end

    assign pending_count = expected_results.size();

    always @(posedge clk) begin
        cell_result_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                    s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("read_value", m_tdata[31:0], want.value);
                    if (m_tdata[32] !== want.found)
                        report_mismatch("found", m_tdata[32], want.found);
                    if (m_tdata[33] !== want.dropped)
                        report_mismatch("dropped", m_tdata[33], want.dropped);
                    if (m_tdata[39:34] !== 6'd0)
                        report_mismatch("pad", m_tdata[39:34], 32'd0);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Top of the cell store testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import s3c_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // tdata from bit 0: coord_x, coord_y, coord_z, write_value
    logic [127:0] s_tdata;
    // tuser: req_type
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // tdata from bit 0: read_value, found, dropped, zero pad
    logic [39:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    bit           hold_off;
    bit           stim_done;

    // A small pool of coordinates keeps buckets busy with hits, updates and
    // deletes; the pool includes one colliding-bucket set built at start.
    logic [31:0]  pool_x [64];
    logic [31:0]  pool_y [64];
    logic [31:0]  pool_z [64];

    sparse_3d_cell_hash_store_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cell_store_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sends one beat: held at falling edges until accepted.
    task automatic send_beat(logic kind, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {v, z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        s_tuser  <= $urandom;
        s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return SPACE_VALUE;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stall pattern, one long hold-off mid-run.
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 3) != 0) || stim_done;
        end
    end

    initial begin
        int x0, base_x;
        int idx, n_burst;
        s_tvalid = 1'b0;
        s_tuser = REQ_WRITE;
        s_tdata = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        foreach (pool_x[i]) begin
            pool_x[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7) - 4;
            pool_y[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7) - 4;
            pool_z[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7) - 4;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, read of an absent cell, delete of an absent cell,
        // insert, update, read back, delete and then fill one bucket past full
        // by varying only x along a run until 10 writes target one bucket.
        send_beat(REQ_READ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0);
        send_beat(REQ_WRITE, 32'd1, 32'd2, 32'd3, SPACE_VALUE);
        send_beat(REQ_WRITE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        send_beat(REQ_WRITE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
        send_beat(REQ_READ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(REQ_WRITE, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'hffff_ffff);
        send_beat(REQ_WRITE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, SPACE_VALUE);
        send_beat(REQ_READ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0);
        // Fill a bucket: checker hash decides which x values collide.
        x0 = 0;
        base_x = checker_i.bucket_index(0, 5, 5);
        idx = 0;
        while (idx < 10) begin
            if (checker_i.bucket_index(x0, 5, 5) == base_x) begin
                send_beat(REQ_WRITE, x0, 5, 5, x0 + 100);
                pool_x[idx] = x0;
                pool_y[idx] = 5;
                pool_z[idx] = 5;
                idx++;
            end
            x0++;
        end
        // Delete from the middle of the full bucket, read one cell back, then write a dropped cell.
        send_beat(REQ_WRITE, pool_x[2], 5, 5, SPACE_VALUE);
        send_beat(REQ_READ, pool_x[7], 5, 5, 32'd0);
        send_beat(REQ_WRITE, pool_x[9], 5, 5, 32'd7);

        // Random part in bursts; one long receiver hold-off in the middle.
        for (int n = 0; n < 1100; ) begin
            n_burst = $urandom_range(1, 12);
            for (int k = 0; k < n_burst; k++) begin
                if (n == 500) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_beat($urandom, $urandom, $urandom, $urandom, rand_value());
                end else begin
                    idx = $urandom_range(0, 63);
                    send_beat($urandom, pool_x[idx], pool_y[idx], pool_z[idx],
                              rand_value());
                end
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 30));
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
